>>> src/tgr_pkg.sv
package tgr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MS_CFG_W   = 16;
  localparam int SWIPE_W    = 12;
  localparam int SCALE_W    = 12;
  localparam int ELAPSED_W  = 10;
  localparam int EVENT_W    = 4;
  localparam int MOVE_W     = 16;
  localparam int FRAC_W     = 14;
  localparam int NSLOTS     = 7;
  localparam int SLOT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MAX_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SCALE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_EN      = 3'd7;

  localparam logic [MS_CFG_W-1:0] HOLD_MS_RST      = 16'd250;
  localparam logic [MS_CFG_W-1:0] TAP_MAX_MS_RST   = 16'd250;
  localparam logic [MS_CFG_W-1:0] DOUBLE_TAP_RST   = 16'd750;
  localparam logic [MS_CFG_W-1:0] SWIPE_MAX_MS_RST = 16'd1500;
  localparam logic [SWIPE_W-1:0]  HORIZ_MIN_RST    = 12'd80;
  localparam logic [SWIPE_W-1:0]  VERT_MIN_RST     = 12'd80;
  localparam logic [SCALE_W-1:0]  PAD_SCALE_RST    = 12'd100;

  localparam logic [EVENT_W-1:0] EV_DOWN       = 4'd0;
  localparam logic [EVENT_W-1:0] EV_HOLD       = 4'd1;
  localparam logic [EVENT_W-1:0] EV_MOVE       = 4'd2;
  localparam logic [EVENT_W-1:0] EV_TAP        = 4'd3;
  localparam logic [EVENT_W-1:0] EV_DOUBLE     = 4'd4;
  localparam logic [EVENT_W-1:0] EV_BACK       = 4'd5;
  localparam logic [EVENT_W-1:0] EV_FORWARD    = 4'd6;
  localparam logic [EVENT_W-1:0] EV_SWIPE_UP   = 4'd7;
  localparam logic [EVENT_W-1:0] EV_SWIPE_DOWN = 4'd8;
  localparam logic [EVENT_W-1:0] EV_UP         = 4'd9;

  localparam logic [SLOT_W-1:0] SLOT_DOWN   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_HOLD   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_MOVE   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TAP    = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_DOUBLE = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_SWIPE  = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_UP     = 3'd6;

  localparam logic [MOVE_W-1:0] Q_ONE = 16'd16384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_req;
    logic any_event;
    logic div_done;
    logic out_free;
    logic final_word;
  } dp_status_t;

endpackage

>>> src/touchpad_gesture_recognizer_top.sv
// Touchpad gesture recogniser. Each input word is one touchpad sample; it
// produces up to five result words in order (down, hold, move, tap, double
// tap, swipe, up), the last one flagged by last_event. A sample is accepted
// in ST_IDLE and evaluated in ST_EVAL, then its result words are loaded one
// by one into the output register whenever that register is free. With
// movement_enable set, a bit-serial divider scales both axes in parallel
// before the result words of any sample with the finger on the pad now or
// before. in_stall stays high until the final word is in the output
// register. Configuration writes are applied at once and must only be made
// while the block is idle.
module touchpad_gesture_recognizer_top #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                touching,
  input  logic [COORD_BITS-1:0]               pos_x,
  input  logic [COORD_BITS-1:0]               pos_y,
  input  logic [tgr_pkg::ELAPSED_W-1:0]       elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tgr_pkg::EVENT_W-1:0]         event_code,
  output logic signed [tgr_pkg::MOVE_W-1:0]   move_x,
  output logic signed [tgr_pkg::MOVE_W-1:0]   move_y,
  output logic                                last_event
);
  import tgr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tgr_datapath #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .touching   (touching),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .elapsed_ms (elapsed_ms),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code),
    .move_x     (move_x),
    .move_y     (move_y),
    .last_event (last_event)
  );

endmodule

>>> src/tgr_ctrl.sv
module tgr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tgr_pkg::dp_status_t   status,
  output tgr_pkg::ctrl_cmd_t    cmd
);
  import tgr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.move_req)       state_next = ST_DIVIDE;
        else if (status.any_event) state_next = ST_EMIT;
        else                       state_next = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.final_word) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EVAL:   cmd.eval = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_EMIT:   cmd.emit = status.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> $past(state == ST_EVAL) || $past(state == ST_DIVIDE))
    else $error("divide entered from wrong state");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EVAL))
    else $error("accepted word not evaluated");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && status.out_free && status.final_word |=> in_stall == 1'b0)
    else $error("input not released after final word");

endmodule

>>> src/tgr_datapath.sv
module tgr_datapath #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                touching,
  input  logic [COORD_BITS-1:0]               pos_x,
  input  logic [COORD_BITS-1:0]               pos_y,
  input  logic [tgr_pkg::ELAPSED_W-1:0]       elapsed_ms,
  input  tgr_pkg::ctrl_cmd_t                  cmd,
  output tgr_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tgr_pkg::EVENT_W-1:0]         event_code,
  output logic signed [tgr_pkg::MOVE_W-1:0]   move_x,
  output logic signed [tgr_pkg::MOVE_W-1:0]   move_y,
  output logic                                last_event
);
  import tgr_pkg::*;

  localparam int CMP_W = (TIME_BITS > MS_CFG_W) ? TIME_BITS : MS_CFG_W;
  localparam int MAG_W = (COORD_BITS > SWIPE_W) ? COORD_BITS : SWIPE_W;
  localparam int D_W   = SCALE_W + 1;
  localparam int N_W   = COORD_BITS + FRAC_W + 1;
  localparam int CNT_W = $clog2(N_W);

  // configuration
  logic [MS_CFG_W-1:0] hold_ms, tap_max_ms, double_tap_ms, swipe_max_ms;
  logic [SWIPE_W-1:0]  horiz_swipe_min, vert_swipe_min;
  logic [SCALE_W-1:0]  pad_scale;
  logic                movement_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms         <= HOLD_MS_RST;
      tap_max_ms      <= TAP_MAX_MS_RST;
      double_tap_ms   <= DOUBLE_TAP_RST;
      swipe_max_ms    <= SWIPE_MAX_MS_RST;
      horiz_swipe_min <= HORIZ_MIN_RST;
      vert_swipe_min  <= VERT_MIN_RST;
      pad_scale       <= PAD_SCALE_RST;
      movement_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_HOLD_MS:      hold_ms         <= cfg_data;
        REG_TAP_MAX_MS:   tap_max_ms      <= cfg_data;
        REG_DOUBLE_TAP:   double_tap_ms   <= cfg_data;
        REG_SWIPE_MAX_MS: swipe_max_ms    <= cfg_data;
        REG_HORIZ_MIN:    horiz_swipe_min <= cfg_data[SWIPE_W-1:0];
        REG_VERT_MIN:     vert_swipe_min  <= cfg_data[SWIPE_W-1:0];
        REG_PAD_SCALE:    pad_scale       <= cfg_data[SCALE_W-1:0];
        REG_MOVE_EN:      movement_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample
  logic                  s_touch;
  logic [COORD_BITS-1:0] s_x, s_y;
  logic [ELAPSED_W-1:0]  s_el;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_touch <= touching;
      s_x     <= pos_x;
      s_y     <= pos_y;
      s_el    <= elapsed_ms;
    end
  end

  // gesture state
  logic                  was_touching, stationary, hold_done, prior_tap_valid;
  logic [COORD_BITS-1:0] down_x, down_y;
  logic [TIME_BITS-1:0]  since_down_ms, since_tap_ms;

  logic                  idle_smp, down_ev, release_ev;
  logic [TIME_BITS:0]    sd_sum, st_sum;
  logic [TIME_BITS-1:0]  sd_add, st_add, sd_eff;
  logic [COORD_BITS-1:0] ref_x, ref_y;
  logic                  stat_eff, hold_fire, move_fire, tap_fire, dbl_fire;
  logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] ax, ay;
  logic                  dx_pos, dy_pos, h_sw, v_sw, swipe_fire;
  logic [EVENT_W-1:0]    swipe_code;
  logic [NSLOTS-1:0]     ev_mask;
  logic [SCALE_W-1:0]    scale_eff;

  always_comb begin
    idle_smp   = !was_touching && !s_touch;
    down_ev    = !was_touching && s_touch;
    release_ev = was_touching && !s_touch;
    sd_sum = {1'b0, since_down_ms} + (TIME_BITS+1)'(s_el);
    st_sum = {1'b0, since_tap_ms} + (TIME_BITS+1)'(s_el);
    sd_add = sd_sum[TIME_BITS] ? '1 : sd_sum[TIME_BITS-1:0];
    st_add = st_sum[TIME_BITS] ? '1 : st_sum[TIME_BITS-1:0];
    sd_eff = down_ev ? '0 : sd_add;
    ref_x  = down_ev ? s_x : down_x;
    ref_y  = down_ev ? s_y : down_y;
    stat_eff  = (down_ev || stationary) && (s_x == ref_x) && (s_y == ref_y);
    hold_fire = !idle_smp && stat_eff && (down_ev || !hold_done) &&
                (CMP_W'(sd_eff) > CMP_W'(hold_ms));
    move_fire = movement_enable && !idle_smp;
    tap_fire  = release_ev && stat_eff && (CMP_W'(sd_eff) < CMP_W'(tap_max_ms));
    dbl_fire  = tap_fire && prior_tap_valid &&
                (CMP_W'(st_add) < CMP_W'(double_tap_ms));
    dx  = $signed({1'b0, ref_x}) - $signed({1'b0, s_x});
    dy  = $signed({1'b0, ref_y}) - $signed({1'b0, s_y});
    ndx = -dx;
    ndy = -dy;
    ax  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    dx_pos = !dx[COORD_BITS] && (dx != '0);
    dy_pos = !dy[COORD_BITS] && (dy != '0);
    h_sw = (MAG_W'(ax) > MAG_W'(horiz_swipe_min)) && (ax > ay);
    v_sw = (MAG_W'(ay) > MAG_W'(vert_swipe_min)) && (ay > ax);
    swipe_fire = release_ev && !tap_fire && !stat_eff &&
                 (CMP_W'(sd_eff) < CMP_W'(swipe_max_ms)) && (h_sw || v_sw);
    if (h_sw) swipe_code = dx_pos ? EV_BACK : EV_FORWARD;
    else      swipe_code = dy_pos ? EV_SWIPE_UP : EV_SWIPE_DOWN;
    ev_mask = '0;
    ev_mask[SLOT_DOWN]   = down_ev;
    ev_mask[SLOT_HOLD]   = hold_fire;
    ev_mask[SLOT_MOVE]   = move_fire;
    ev_mask[SLOT_TAP]    = tap_fire;
    ev_mask[SLOT_DOUBLE] = dbl_fire;
    ev_mask[SLOT_SWIPE]  = swipe_fire;
    ev_mask[SLOT_UP]     = release_ev;
    scale_eff = (pad_scale == '0) ? SCALE_W'(1) : pad_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touching    <= 1'b0;
      down_x          <= '0;
      down_y          <= '0;
      stationary      <= 1'b0;
      hold_done       <= 1'b0;
      prior_tap_valid <= 1'b0;
      since_down_ms   <= '1;
      since_tap_ms    <= '1;
    end else if (cmd.eval) begin
      was_touching  <= s_touch;
      since_down_ms <= sd_eff;
      since_tap_ms  <= (tap_fire && !dbl_fire) ? '0 : st_add;
      if (!idle_smp) begin
        down_x     <= ref_x;
        down_y     <= ref_y;
        stationary <= stat_eff;
        hold_done  <= (hold_done && !down_ev) || hold_fire;
      end
      if (release_ev) prior_tap_valid <= tap_fire && !dbl_fire;
    end
  end

  // bit-serial restoring divider, one lane per axis
  logic [N_W-1:0]   quo [2];
  logic [D_W-1:0]   rem [2];
  logic [D_W-1:0]   dvsr;
  logic [CNT_W-1:0] cnt;
  logic             neg [2];
  logic [D_W:0]     rsh [2];
  logic [D_W:0]     rdif [2];
  logic             qbit [2];
  logic [MOVE_W-1:0] sat [2];
  logic [MOVE_W-1:0] mv [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rsh[i]  = {rem[i], quo[i][N_W-1]};
      rdif[i] = rsh[i] - {1'b0, dvsr};
      qbit[i] = rsh[i] >= {1'b0, dvsr};
      sat[i]  = (quo[i] > N_W'(Q_ONE)) ? Q_ONE : quo[i][MOVE_W-1:0];
      mv[i]   = neg[i] ? -sat[i] : sat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dvsr   <= {scale_eff, 1'b0};
      quo[0] <= N_W'({ax, {FRAC_W{1'b0}}}) + N_W'(scale_eff);
      quo[1] <= N_W'({ay, {FRAC_W{1'b0}}}) + N_W'(scale_eff);
      rem[0] <= '0;
      rem[1] <= '0;
      neg[0] <= dx[COORD_BITS];
      neg[1] <= dy[COORD_BITS];
      cnt    <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        rem[i] <= qbit[i] ? rdif[i][D_W-1:0] : rsh[i][D_W-1:0];
        quo[i] <= {quo[i][N_W-2:0], qbit[i]};
      end
      cnt <= cnt + CNT_W'(1);
    end
  end

  // result words
  logic [NSLOTS-1:0] pend, pend_rest;
  logic [EVENT_W-1:0] swipe_reg;
  logic [SLOT_W-1:0]  sel;
  logic [EVENT_W-1:0] sel_code;

  always_comb begin
    sel = SLOT_UP;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel = SLOT_W'(i);
    end
    pend_rest      = pend;
    pend_rest[sel] = 1'b0;
    unique case (sel)
      SLOT_DOWN:   sel_code = EV_DOWN;
      SLOT_HOLD:   sel_code = EV_HOLD;
      SLOT_MOVE:   sel_code = EV_MOVE;
      SLOT_TAP:    sel_code = EV_TAP;
      SLOT_DOUBLE: sel_code = EV_DOUBLE;
      SLOT_SWIPE:  sel_code = swipe_reg;
      default:     sel_code = EV_UP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.eval) begin
        pend <= ev_mask;
      end else if (cmd.emit) begin
        pend <= pend_rest;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) swipe_reg <= swipe_code;
    if (cmd.emit) begin
      event_code <= sel_code;
      move_x     <= (sel == SLOT_MOVE) ? mv[0] : '0;
      move_y     <= (sel == SLOT_MOVE) ? mv[1] : '0;
      last_event <= (pend_rest == '0);
    end
  end

  assign status.move_req   = move_fire;
  assign status.any_event  = |ev_mask;
  assign status.div_done   = (cnt == CNT_W'(N_W - 1));
  assign status.out_free   = !out_valid || !out_stall;
  assign status.final_word = (pend_rest == '0);

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (pend != '0))
    else $error("word loaded with nothing pending");

  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.final_word |=> (pend == '0) && last_event)
    else $error("final word not flagged");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code != EV_MOVE) |-> (move_x == '0) && (move_y == '0))
    else $error("movement on a non-movement word");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_MOVE) |->
      (move_x <= $signed(Q_ONE)) && (move_x >= -$signed(Q_ONE)) &&
      (move_y <= $signed(Q_ONE)) && (move_y >= -$signed(Q_ONE)))
    else $error("movement out of range");

endmodule
